FILE: rtl/core/aes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and GF(2^8) helpers for the AES block engine.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int unsigned KeyRegs    = 4;
	localparam int unsigned StoreDepth = 60;
	localparam int unsigned StoreRows  = StoreDepth / 4;
	localparam int unsigned AddrW      = 6;

	// configuration register indexes
	localparam logic [2:0] RegKey0   = 3'd0;
	localparam logic [2:0] RegKey1   = 3'd1;
	localparam logic [2:0] RegKey2   = 3'd2;
	localparam logic [2:0] RegKey3   = 3'd3;
	localparam logic [2:0] RegKeyLen = 3'd4;

	// key length codes
	localparam logic [1:0] Klen128 = 2'd0;
	localparam logic [1:0] Klen192 = 2'd1;
	localparam logic [1:0] Klen256 = 2'd2;

	localparam logic CmdEncrypt = 1'b0;
	localparam logic CmdDecrypt = 1'b1;

	// controller to datapath commands
	typedef enum logic [2:0] {
		DP_NOP,
		DP_KEY_LOAD,   // copy one key word into the store
		DP_KEY_STEP,   // derive one schedule word
		DP_BLK_CAP,    // capture the accepted block
		DP_BLK_LOAD,   // first round key add
		DP_ROUND,      // one full round
		DP_LAST        // final round
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [AddrW-1:0] waddr;    // schedule word being written
		logic [2:0]       kidx;     // key word index for a load
		logic             sub_rot;  // rot + sub + rcon
		logic             sub_only; // sub only (256-bit i%8==4)
		logic             rcon_adv;
		logic             rcon_clr;
		logic [3:0]       rnd;      // round key to fetch
		logic             dec;
	} dp_cmd_t;

	function automatic logic [7:0] xtime(input logic [7:0] x);
		xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[x];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		inv_sbox = t[x];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/aes_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_datapath
// Key registers, round key store, key expansion step and one AES round unit.
// ----------------------------------------------------------------------------
module aes_datapath (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire [2:0]             cfg_idx,
	input  wire [63:0]            cfg_data,
	input  aes_pkg::dp_cmd_t      cmd,
	input  wire [63:0]            block_hi,
	input  wire [63:0]            block_lo,
	output logic [1:0]            key_len,
	output logic [63:0]           out_hi,
	output logic [63:0]           out_lo
);

	logic [63:0] key_q [aes_pkg::KeyRegs];
	logic [1:0]  klen_q;
	// round key store: one bank per column, one row per round
	logic [31:0] bank0_q [aes_pkg::StoreRows];
	logic [31:0] bank1_q [aes_pkg::StoreRows];
	logic [31:0] bank2_q [aes_pkg::StoreRows];
	logic [31:0] bank3_q [aes_pkg::StoreRows];
	logic [127:0] state_q;
	logic [7:0]  rcon_q;
	logic [31:0] prev_q;        // last schedule word written
	logic [127:0] rk;
	logic [aes_pkg::AddrW-1:0] nk;
	logic [aes_pkg::AddrW-1:0] back_addr;
	logic [aes_pkg::AddrW-3:0] back_row, wr_row;
	logic [31:0] back_w, t_w, new_w, rot_w;
	logic [63:0] kw;
	logic [127:0] blk_in, enc_nx, dec_nx, enc_last, dec_last;

	assign key_len = klen_q;
	assign out_hi  = state_q[127:64];
	assign out_lo  = state_q[63:0];

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < aes_pkg::KeyRegs; i++) key_q[i] <= '0;
			klen_q <= aes_pkg::Klen128;
		end else if (cfg_we) begin
			case (cfg_idx)
				aes_pkg::RegKey0: key_q[0] <= cfg_data;
				aes_pkg::RegKey1: key_q[1] <= cfg_data;
				aes_pkg::RegKey2: key_q[2] <= cfg_data;
				aes_pkg::RegKey3: key_q[3] <= cfg_data;
				aes_pkg::RegKeyLen: klen_q <= (cfg_data[1:0] == 2'd3) ? aes_pkg::Klen256
					: cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// schedule step
	assign nk = (klen_q == aes_pkg::Klen128) ? 6'd4 : (klen_q == aes_pkg::Klen192) ? 6'd6 : 6'd8;
	assign back_addr = cmd.waddr - nk;
	assign back_row  = back_addr[aes_pkg::AddrW-1:2];
	assign wr_row    = cmd.waddr[aes_pkg::AddrW-1:2];
	assign rot_w = {prev_q[23:0], prev_q[31:24]};
	always_comb begin
		t_w = prev_q;
		if (cmd.sub_rot) begin
			t_w = {aes_pkg::sbox(rot_w[31:24]) ^ rcon_q, aes_pkg::sbox(rot_w[23:16]),
				aes_pkg::sbox(rot_w[15:8]), aes_pkg::sbox(rot_w[7:0])};
		end else if (cmd.sub_only) begin
			t_w = {aes_pkg::sbox(prev_q[31:24]), aes_pkg::sbox(prev_q[23:16]),
				aes_pkg::sbox(prev_q[15:8]), aes_pkg::sbox(prev_q[7:0])};
		end
	end

	// fetch the word nk back from its bank
	always_comb begin
		case (back_addr[1:0])
			2'd0: back_w = bank0_q[back_row];
			2'd1: back_w = bank1_q[back_row];
			2'd2: back_w = bank2_q[back_row];
			default: back_w = bank3_q[back_row];
		endcase
	end

	assign kw     = key_q[cmd.kidx[2:1]];
	assign new_w  = (cmd.op == aes_pkg::DP_KEY_LOAD) ? (cmd.kidx[0] ? kw[31:0] : kw[63:32])
		: (back_w ^ t_w);

	// write the store
	always_ff @(posedge clk) begin
		if (cmd.op == aes_pkg::DP_KEY_LOAD || cmd.op == aes_pkg::DP_KEY_STEP) begin
			case (cmd.waddr[1:0])
				2'd0: bank0_q[wr_row] <= new_w;
				2'd1: bank1_q[wr_row] <= new_w;
				2'd2: bank2_q[wr_row] <= new_w;
				default: bank3_q[wr_row] <= new_w;
			endcase
			prev_q <= new_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rcon_q <= 8'h01;
		else if (cmd.rcon_clr) rcon_q <= 8'h01;
		else if (cmd.rcon_adv) rcon_q <= aes_pkg::xtime(rcon_q);
	end

	// fetch the round key, one row across the banks
	assign rk = {bank0_q[cmd.rnd], bank1_q[cmd.rnd], bank2_q[cmd.rnd], bank3_q[cmd.rnd]};

	// one round each way
	always_comb begin
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
		logic [7:0] e0, e1, e2, e3;
		blk_in = {block_hi, block_lo};
		for (int j = 0; j < 16; j++) s[j] = state_q[127-8*j -: 8];
		// encrypt: sub, shift rows
		for (int c = 0; c < 4; c++)
			for (int j = 0; j < 4; j++)
				t[c*4+j] = aes_pkg::sbox(s[((c+j)%4)*4+j]);
		for (int j = 0; j < 16; j++) enc_last[127-8*j -: 8] = t[j];
		for (int c = 0; c < 4; c++) begin
			a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
			enc_nx[127-32*c -: 8]  = aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
			enc_nx[119-32*c -: 8]  = a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3;
			enc_nx[111-32*c -: 8]  = a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3;
			enc_nx[103-32*c -: 8]  = aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3);
		end
		// decrypt: inverse shift, inverse sub, key add, then inverse mix
		for (int c = 0; c < 4; c++)
			for (int j = 0; j < 4; j++)
				t[((c+j)%4)*4+j] = s[c*4+j];
		for (int j = 0; j < 16; j++) t[j] = aes_pkg::inv_sbox(t[j]) ^ rk[127-8*j -: 8];
		for (int j = 0; j < 16; j++) dec_last[127-8*j -: 8] = t[j];
		for (int c = 0; c < 4; c++) begin
			a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
			// x9, x11, x13, x14 via x2, x4, x8
			b0 = aes_pkg::xtime(a0); b1 = aes_pkg::xtime(a1);
			b2 = aes_pkg::xtime(a2); b3 = aes_pkg::xtime(a3);
			e0 = aes_pkg::xtime(aes_pkg::xtime(a0 ^ a2)); // 4a0 ^ 4a2
			e1 = aes_pkg::xtime(aes_pkg::xtime(a1 ^ a3));
			e2 = aes_pkg::xtime(e0 ^ e1);                 // 8 * all
			e3 = a0 ^ a1 ^ a2 ^ a3 ^ e2;
			dec_nx[127-32*c -: 8] = e3 ^ b0 ^ b1 ^ a0 ^ e0;
			dec_nx[119-32*c -: 8] = e3 ^ b1 ^ b2 ^ a1 ^ e1;
			dec_nx[111-32*c -: 8] = e3 ^ b2 ^ b3 ^ a2 ^ e0;
			dec_nx[103-32*c -: 8] = e3 ^ b3 ^ b0 ^ a3 ^ e1;
		end
	end

	// advance the block state
	always_ff @(posedge clk) begin
		case (cmd.op)
			aes_pkg::DP_BLK_CAP:  state_q <= blk_in;
			aes_pkg::DP_BLK_LOAD: state_q <= state_q ^ rk;
			aes_pkg::DP_ROUND:    state_q <= cmd.dec ? dec_nx : (enc_nx ^ rk);
			aes_pkg::DP_LAST:     state_q <= cmd.dec ? dec_last : (enc_last ^ rk);
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/aes_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_ctrl
// Sequencer: expands the schedule when stale, then runs the rounds.
// ----------------------------------------------------------------------------
module aes_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire               dec,
	input  wire               cfg_hit,
	input  wire [1:0]         key_len,
	output logic              busy,
	output logic              done,
	output aes_pkg::dp_cmd_t  cmd
);

	typedef enum logic [1:0] {S_IDLE, S_EXPAND, S_LOAD, S_RUN} state_t;

	state_t    state_q;
	logic      ready_q, dec_q, done_q;
	logic [5:0] addr_q;
	logic [2:0] mod_q;   // addr modulo nk
	logic [3:0] rnd_q;
	logic [5:0] nk, total;
	logic [3:0] nr;

	assign nk = (key_len == aes_pkg::Klen128) ? 6'd4 : (key_len == aes_pkg::Klen192) ? 6'd6 : 6'd8;
	assign total = (key_len == aes_pkg::Klen128) ? 6'd44
		: (key_len == aes_pkg::Klen192) ? 6'd52 : 6'd60;
	assign nr = 4'(nk) + 4'd6;
	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	// issue datapath commands
	always_comb begin
		cmd = '0;
		cmd.op = aes_pkg::DP_NOP;
		cmd.dec = dec_q;
		cmd.waddr = addr_q;
		cmd.kidx = addr_q[2:0];
		cmd.rnd = rnd_q;
		case (state_q)
			S_IDLE: begin
				cmd.rcon_clr = 1'b1;
				if (start) cmd.op = aes_pkg::DP_BLK_CAP;
			end
			S_EXPAND: begin
				if (addr_q < nk) cmd.op = aes_pkg::DP_KEY_LOAD;
				else begin
					cmd.op = aes_pkg::DP_KEY_STEP;
					cmd.sub_rot = (mod_q == 3'd0);
					cmd.rcon_adv = (mod_q == 3'd0);
					cmd.sub_only = (nk == 6'd8) && (mod_q == 3'd4);
				end
			end
			S_LOAD: cmd.op = aes_pkg::DP_BLK_LOAD;
			S_RUN: cmd.op = ((dec_q && rnd_q == 4'd0) || (!dec_q && rnd_q == nr))
				? aes_pkg::DP_LAST : aes_pkg::DP_ROUND;
			default: ;
		endcase
	end

	// sequence one block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b0;
			dec_q   <= 1'b0;
			done_q  <= 1'b0;
			addr_q  <= '0;
			mod_q   <= '0;
			rnd_q   <= '0;
		end else begin
			done_q <= (state_q == S_RUN) && (cmd.op == aes_pkg::DP_LAST);
			if (cfg_hit) ready_q <= 1'b0;
			else if (state_q == S_EXPAND && addr_q + 6'd1 == total) ready_q <= 1'b1;
			case (state_q)
				S_IDLE: if (start) begin
					dec_q  <= dec;
					addr_q <= '0;
					mod_q  <= '0;
					rnd_q  <= dec ? nr : 4'd0;
					state_q <= ready_q ? S_LOAD : S_EXPAND;
				end
				S_EXPAND: begin
					addr_q <= addr_q + 6'd1;
					mod_q  <= (6'(mod_q) + 6'd1 == nk) ? 3'd0 : mod_q + 3'd1;
					if (addr_q + 6'd1 == total) state_q <= S_LOAD;
				end
				S_LOAD: begin
					rnd_q <= dec_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
					state_q <= S_RUN;
				end
				S_RUN: begin
					rnd_q <= dec_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
					if (cmd.op == aes_pkg::DP_LAST) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/aes_block_cipher_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_block_cipher_top
// AES-128/192/256 single block engine, ECB, encrypt and decrypt.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  input    | start & !busy         | cmd, block_hi, block_lo
//  result   | done (one cycle)      | out_hi, out_lo
//  config   | cfg_valid & cfg_ready | cfg_index, cfg_data
//
// A block takes a load step, then one round a cycle through a single round
// unit. After reset or any key or key length write the first block first
// expands the schedule, one word a cycle.
// Results cannot be stalled; done pulses for one cycle with the result.
module aes_block_cipher_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         cmd,
	input  wire [63:0]  block_hi,
	input  wire [63:0]  block_lo,
	output logic        done,
	output logic [63:0] out_hi,
	output logic [63:0] out_lo,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire [2:0]   cfg_index,
	input  wire [63:0]  cfg_data
);

	aes_pkg::dp_cmd_t dp_cmd;
	logic [1:0] key_len;
	logic cfg_we, cfg_hit;

	assign cfg_ready = 1'b1;
	assign cfg_we  = cfg_valid & cfg_ready;
	assign cfg_hit = cfg_we && (cfg_index <= aes_pkg::RegKeyLen);

	aes_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.dec     (cmd),
		.cfg_hit (cfg_hit),
		.key_len (key_len),
		.busy    (busy),
		.done    (done),
		.cmd     (dp_cmd)
	);

	aes_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_index),
		.cfg_data (cfg_data),
		.cmd      (dp_cmd),
		.block_hi (block_hi),
		.block_lo (block_lo),
		.key_len  (key_len),
		.out_hi   (out_hi),
		.out_lo   (out_lo)
	);

endmodule

`default_nettype wire

FILE: rtl/core/aes_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_checker
// Port-level checks on the block engine's command and result beats.
// ----------------------------------------------------------------------------
module aes_checker (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire busy,
	input wire done
);

	// a result beat ends the busy period
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	// an accepted beat makes the engine busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");

	// results come only after a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(busy)) else $error("spurious done");

	// a result beat is never directly followed by another
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");

endmodule

bind aes_block_cipher_top aes_checker u_aes_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire
